>>> hw/rtl/dmcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmcg_pkg: shared types and constants for the dead-man motion command gate
// Holds the request and configuration records, the kind, status and register
// index codes, and the timer width.
// ----------------------------------------------------------------------------
package dmcg_pkg;

	// Timer width for the command and speed-step ages
	localparam int AGE_BITS = 16;
	// Compare width covering both the ages and the 16-bit tick registers
	localparam int CMP_W    = (AGE_BITS > 16) ? AGE_BITS : 16;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// Reset values of the configuration registers
	localparam logic [6:0]  DEADBAND_RST = 7'd5;
	localparam logic [7:0]  MAX_STEP_RST = 8'd5;
	localparam logic [15:0] TIMEOUT_RST  = 16'd500;
	localparam logic [6:0]  SPD_STEP_RST = 7'd5;
	localparam logic [15:0] REPEAT_RST   = 16'd120;

	// Drive limits
	localparam logic signed [7:0] DRIVE_MAX = 8'sd100;
	localparam logic signed [7:0] DRIVE_MIN = -8'sd100;
	localparam logic [6:0]        LEVEL_MAX = 7'd100;

	typedef enum logic [1:0] {
		KIND_COMMAND = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_FAULT   = 2'd2,
		KIND_SESSION = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_APPLIED = 2'd0,
		ST_WAIT    = 2'd1,
		ST_STOPPED = 2'd2,
		ST_HELD    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND = 3'd0,
		REG_MAX_STEP = 3'd1,
		REG_TIMEOUT  = 3'd2,
		REG_SPD_STEP = 3'd3,
		REG_REPEAT   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [6:0]  servo_deadband;
		logic [7:0]  servo_max_step;
		logic [15:0] timeout_ticks;
		logic [6:0]  speed_step;
		logic [15:0] speed_repeat_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic signed [7:0] left_stick;
		logic signed [7:0] right_stick;
		logic signed [7:0] left_trigger;
		logic signed [7:0] right_trigger;
		logic              deadman;
		logic              speed_up;
		logic              speed_down;
		logic              estop_request;
	} req_t;

endpackage
`default_nettype wire

>>> hw/rtl/dmcg_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmcg_cfg: configuration register file
// Five write-only registers, loaded from the write port by index.
// ----------------------------------------------------------------------------
module dmcg_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [dmcg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dmcg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output dmcg_pkg::cfg_t                       cfg
);
	import dmcg_pkg::*;

	cfg_t cfg_q;

	// Load the addressed register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.servo_deadband     <= DEADBAND_RST;
			cfg_q.servo_max_step     <= MAX_STEP_RST;
			cfg_q.timeout_ticks      <= TIMEOUT_RST;
			cfg_q.speed_step         <= SPD_STEP_RST;
			cfg_q.speed_repeat_ticks <= REPEAT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DEADBAND: cfg_q.servo_deadband     <= cfg_wdata[6:0];
				REG_MAX_STEP: cfg_q.servo_max_step     <= cfg_wdata[7:0];
				REG_TIMEOUT:  cfg_q.timeout_ticks      <= cfg_wdata[15:0];
				REG_SPD_STEP: cfg_q.speed_step         <= cfg_wdata[6:0];
				REG_REPEAT:   cfg_q.speed_repeat_ticks <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> hw/rtl/dmcg_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmcg_core: gate state update and result register
// Applies one request per cycle to the gate state unless a result stalls.
// Output state registers, with status and valid, form the result register.
// ----------------------------------------------------------------------------
module dmcg_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dmcg_pkg::cfg_t    cfg,
	input  wire logic              item_valid,
	input  wire dmcg_pkg::req_t    item,
	output logic                   item_take,
	input  wire logic              res_ready,
	output logic                   res_valid,
	output logic signed [7:0]      left_wing_out,
	output logic signed [7:0]      right_wing_out,
	output logic signed [7:0]      vector_out,
	output logic [6:0]             speed_out,
	output logic                   armed_out,
	output logic [1:0]             status
);
	import dmcg_pkg::*;

	// State
	logic                  stop_latch_q, armed_q, has_stepped_q, command_seen_q;
	logic [6:0]            speed_target_q, held_speed_q;
	logic signed [7:0]     vector_pos_q, held_left_q, held_right_q;
	logic [AGE_BITS-1:0]   step_age_q, command_age_q;
	status_t               status_q;
	logic                  res_valid_q;

	// Next state
	logic                  stop_latch_d, armed_d, has_stepped_d, command_seen_d;
	logic [6:0]            speed_target_d, held_speed_d;
	logic signed [7:0]     vector_pos_d, held_left_d, held_right_d;
	logic [AGE_BITS-1:0]   step_age_d, command_age_d;
	status_t               status_d;

	// Command decode
	logic signed [7:0]     lw, rw;
	logic [6:0]            lt, rt;
	logic                  enabled, step_ok, neutral;
	logic [7:0]            spd_sum;
	logic [6:0]            spd_new, spd;
	logic [AGE_BITS-1:0]   step_age_inc, cmd_age_inc;

	// Vector slew
	logic signed [9:0]     pos10, tgt_l, tgt_r, tgt, delta, stp10;
	logic                  hl, hr;

	function automatic logic signed [7:0] clamp_stick(input logic signed [7:0] x);
		if (x < DRIVE_MIN)
			return DRIVE_MIN;
		else if (x > DRIVE_MAX)
			return DRIVE_MAX;
		else
			return x;
	endfunction

	function automatic logic [6:0] clamp_level(input logic signed [7:0] x);
		if (x[7])
			return 7'd0;
		else if (x > DRIVE_MAX)
			return LEVEL_MAX;
		else
			return x[6:0];
	endfunction

	function automatic logic signed [9:0] abs10(input logic signed [9:0] x);
		return x[9] ? -x : x;
	endfunction

	function automatic logic [AGE_BITS-1:0] age_sat(input logic [AGE_BITS-1:0] a);
		return (&a) ? a : a + AGE_BITS'(1);
	endfunction

	assign item_take    = item_valid && (!res_valid_q || res_ready);
	assign step_age_inc = age_sat(step_age_q);
	assign cmd_age_inc  = age_sat(command_age_q);

	// Gate the command: latch, enable, speed step
	always_comb begin
		stop_latch_d = stop_latch_q;
		if (item.estop_request)
			stop_latch_d = 1'b1;
		if (!item.deadman)
			stop_latch_d = 1'b0;
		enabled = item.deadman && !stop_latch_d;

		step_ok = !item.estop_request && enabled && (item.speed_up != item.speed_down)
			&& (!has_stepped_q
			|| CMP_W'(step_age_q) >= CMP_W'(cfg.speed_repeat_ticks));

		spd_sum = {1'b0, speed_target_q} + {1'b0, cfg.speed_step};
		if (item.speed_up)
			spd_new = (spd_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : spd_sum[6:0];
		else
			spd_new = (cfg.speed_step > speed_target_q) ? 7'd0
				: speed_target_q - cfg.speed_step;
		spd = step_ok ? spd_new : speed_target_q;

		lw = enabled ? clamp_stick(item.left_stick) : 8'sd0;
		rw = enabled ? clamp_stick(item.right_stick) : 8'sd0;
		lt = enabled ? clamp_level(item.left_trigger) : 7'd0;
		rt = enabled ? clamp_level(item.right_trigger) : 7'd0;
		if (!enabled)
			spd = 7'd0;

		neutral = !item.estop_request && !enabled && !item.speed_up && !item.speed_down;
	end

	// Pick the vector target and slew toward it
	always_comb begin
		pos10 = 10'(vector_pos_q);
		tgt_l = -$signed({3'b000, lt});
		tgt_r = $signed({3'b000, rt});
		hl    = lt > cfg.servo_deadband;
		hr    = rt > cfg.servo_deadband;
		if (hl && hr)
			tgt = (abs10(tgt_l - pos10) <= abs10(tgt_r - pos10)) ? tgt_l : tgt_r;
		else if (hl)
			tgt = tgt_l;
		else if (hr)
			tgt = tgt_r;
		else
			tgt = 10'sd0;
		stp10 = $signed({2'b00, cfg.servo_max_step});
		delta = tgt - pos10;
		if (delta > stp10)
			vector_pos_d = 8'(pos10 + stp10);
		else if (delta < -stp10)
			vector_pos_d = 8'(pos10 - stp10);
		else
			vector_pos_d = 8'(tgt);
	end

	// Next gate state per request kind
	always_comb begin
		armed_d        = armed_q;
		has_stepped_d  = has_stepped_q;
		command_seen_d = command_seen_q;
		speed_target_d = speed_target_q;
		held_speed_d   = held_speed_q;
		held_left_d    = held_left_q;
		held_right_d   = held_right_q;
		step_age_d     = step_age_q;
		command_age_d  = command_age_q;
		status_d       = ST_STOPPED;

		case (kind_t'(item.kind))
			KIND_COMMAND: begin
				command_age_d  = '0;
				command_seen_d = 1'b1;
				if (!armed_q && !neutral) begin
					status_d = ST_WAIT;
				end else begin
					armed_d       = 1'b1;
					held_left_d   = lw;
					held_right_d  = rw;
					held_speed_d  = spd;
					status_d      = ST_APPLIED;
					if (!enabled) begin
						speed_target_d = '0;
						has_stepped_d  = 1'b0;
						step_age_d     = '0;
					end else if (step_ok) begin
						speed_target_d = spd_new;
						has_stepped_d  = 1'b1;
						step_age_d     = '0;
					end
				end
			end
			KIND_TICK: begin
				step_age_d    = step_age_inc;
				command_age_d = cmd_age_inc;
				if (!command_seen_q || CMP_W'(cmd_age_inc) > CMP_W'(cfg.timeout_ticks))
					status_d = ST_STOPPED;
				else
					status_d = ST_HELD;
			end
			KIND_SESSION: begin
				armed_d  = 1'b0;
				status_d = ST_STOPPED;
			end
			default: begin
				status_d = ST_STOPPED;
			end
		endcase

		// Halt: drop held command and motion state
		if (status_d == ST_STOPPED || status_d == ST_WAIT) begin
			held_left_d    = '0;
			held_right_d   = '0;
			held_speed_d   = '0;
			speed_target_d = '0;
			has_stepped_d  = 1'b0;
			step_age_d     = '0;
		end
	end

	// Hold state and result; advance on each taken request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_latch_q   <= 1'b1;
			armed_q        <= 1'b0;
			has_stepped_q  <= 1'b0;
			command_seen_q <= 1'b0;
			speed_target_q <= '0;
			held_speed_q   <= '0;
			vector_pos_q   <= '0;
			held_left_q    <= '0;
			held_right_q   <= '0;
			step_age_q     <= '0;
			command_age_q  <= '0;
			status_q       <= ST_STOPPED;
			res_valid_q    <= 1'b0;
		end else begin
			res_valid_q <= item_take || (res_valid_q && !res_ready);
			if (item_take) begin
				armed_q        <= armed_d;
				has_stepped_q  <= has_stepped_d;
				command_seen_q <= command_seen_d;
				speed_target_q <= speed_target_d;
				held_speed_q   <= held_speed_d;
				held_left_q    <= held_left_d;
				held_right_q   <= held_right_d;
				step_age_q     <= step_age_d;
				command_age_q  <= command_age_d;
				status_q       <= status_d;
				if (kind_t'(item.kind) == KIND_COMMAND)
					stop_latch_q <= stop_latch_d;
				if (kind_t'(item.kind) == KIND_COMMAND && status_d == ST_APPLIED)
					vector_pos_q <= vector_pos_d;
				else if (status_d == ST_STOPPED || status_d == ST_WAIT)
					vector_pos_q <= '0;
			end
		end
	end

	assign res_valid      = res_valid_q;
	assign left_wing_out  = held_left_q;
	assign right_wing_out = held_right_q;
	assign vector_out     = vector_pos_q;
	assign speed_out      = held_speed_q;
	assign armed_out      = armed_q;
	assign status         = status_q;

	// A stopped or waiting result carries no motion
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (status_q == ST_STOPPED || status_q == ST_WAIT)
		|-> held_left_q == 8'sd0 && held_right_q == 8'sd0 && vector_pos_q == 8'sd0
			&& held_speed_q == 7'd0)
		else $error("stopped result carries motion");

	// Applied command always leaves the gate armed
	a_applied_armed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q == ST_APPLIED |-> armed_q)
		else $error("applied result while disarmed");

	// Waiting for neutral only happens while disarmed
	a_wait_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q == ST_WAIT |-> !armed_q)
		else $error("waiting result while armed");

	// A result held back by the receiver stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |=> res_valid_q && $stable(status_q)
			&& $stable(vector_pos_q))
		else $error("stalled result changed");

	// Speed never leaves its range
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_speed_q <= LEVEL_MAX && speed_target_q <= LEVEL_MAX)
		else $error("speed out of range");

endmodule
`default_nettype wire

>>> hw/rtl/deadman_motion_command_gate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadman_motion_command_gate: safety gate for a drive command
// Request channel req_valid/req_ready carries one item: a command, a
// one-millisecond tick, a fault stop or a session change. Result channel
// res_valid/res_ready returns exactly one result per request: wing drives,
// vector servo position, speed, armed flag and status.
// Each accepted request passes through the request register, then the state
// update writes its result into the result register. One request is taken
// per cycle while the receiver keeps up; the combinational state update
// between the two registers allows this rate.
// An empty request register accepts while a result waits: it refills in
// the cycle the result is taken. When the receiver stalls, the result and
// the request register both hold, and req_ready drops once both are full.
// Reset (arst_n low) disarms the gate, sets the emergency-stop latch, clears
// speed, vector and timers, and loads the configuration defaults.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the
// next clock edge and belong to idle periods only.
// ----------------------------------------------------------------------------
module deadman_motion_command_gate (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [dmcg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dmcg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire logic [1:0]                      kind,
	input  wire logic signed [7:0]               left_stick,
	input  wire logic signed [7:0]               right_stick,
	input  wire logic signed [7:0]               left_trigger,
	input  wire logic signed [7:0]               right_trigger,
	input  wire logic                            deadman,
	input  wire logic                            speed_up,
	input  wire logic                            speed_down,
	input  wire logic                            estop_request,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output logic signed [7:0]                    left_wing_out,
	output logic signed [7:0]                    right_wing_out,
	output logic signed [7:0]                    vector_out,
	output logic [6:0]                           speed_out,
	output logic                                 armed_out,
	output logic [1:0]                           status
);
	import dmcg_pkg::*;

	cfg_t cfg;
	req_t item_s1;
	logic valid_s1;
	logic item_take;

	dmcg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Request register: refill when empty or draining this cycle
	assign req_ready = !valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1.kind          <= kind;
			item_s1.left_stick    <= left_stick;
			item_s1.right_stick   <= right_stick;
			item_s1.left_trigger  <= left_trigger;
			item_s1.right_trigger <= right_trigger;
			item_s1.deadman       <= deadman;
			item_s1.speed_up      <= speed_up;
			item_s1.speed_down    <= speed_down;
			item_s1.estop_request <= estop_request;
		end
	end

	dmcg_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.item_valid     (valid_s1),
		.item           (item_s1),
		.item_take      (item_take),
		.res_ready      (res_ready),
		.res_valid      (res_valid),
		.left_wing_out  (left_wing_out),
		.right_wing_out (right_wing_out),
		.vector_out     (vector_out),
		.speed_out      (speed_out),
		.armed_out      (armed_out),
		.status         (status)
	);

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dead-man motion command gate
// Sends commands, ticks, fault stops and session changes through the request
// channel and compares every result, field by field, with a behavioral
// model of the gate. Both channels idle at random, and configuration is
// changed between phases while the gate is idle.
// ----------------------------------------------------------------------------
module testbench;
	import dmcg_pkg::*;

	localparam int LONG_HOLD = 200;
	localparam int REQ_W = $bits(req_t);
	localparam longint unsigned AGE_TOP = (64'd1 << AGE_BITS) - 64'd1;

	typedef struct {
		logic signed [7:0] drive_l;
		logic signed [7:0] drive_r;
		logic signed [7:0] vector;
		logic [6:0]        speed;
		logic              armed;
		status_t           st;
	} gate_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [1:0] kind = '0;
	logic signed [7:0] left_stick = '0;
	logic signed [7:0] right_stick = '0;
	logic signed [7:0] left_trigger = '0;
	logic signed [7:0] right_trigger = '0;
	logic deadman = 1'b0;
	logic speed_up = 1'b0;
	logic speed_down = 1'b0;
	logic estop_request = 1'b0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic signed [7:0] left_wing_out;
	logic signed [7:0] right_wing_out;
	logic signed [7:0] vector_out;
	logic [6:0] speed_out;
	logic armed_out;
	logic [1:0] status;

	deadman_motion_command_gate dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.kind(kind),
		.left_stick(left_stick),
		.right_stick(right_stick),
		.left_trigger(left_trigger),
		.right_trigger(right_trigger),
		.deadman(deadman),
		.speed_up(speed_up),
		.speed_down(speed_down),
		.estop_request(estop_request),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.left_wing_out(left_wing_out),
		.right_wing_out(right_wing_out),
		.vector_out(vector_out),
		.speed_out(speed_out),
		.armed_out(armed_out),
		.status(status)
	);

	// Model state and configuration
	cfg_t cfg_now;
	bit latch_estop, is_armed, stepped, cmd_seen;
	int spd_target, vec_pos, hold_l, hold_r, hold_spd;
	longint unsigned step_age, cmd_age;

	gate_out_t gate_outputs_due[$];
	int sent_items = 0;
	int checked = 0;
	int failures = 0;
	int input_stalls = 0;
	int cfg_sets = 0;
	int status_hits[4];
	int burst_left = 0;
	bit sender_gaps = 1'b1;
	bit hold_wanted = 1'b0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int clip(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	// Drop the held command, speed and vector position
	function automatic void clear_motion();
		hold_l = 0;
		hold_r = 0;
		hold_spd = 0;
		spd_target = 0;
		stepped = 1'b0;
		step_age = 0;
		vec_pos = 0;
	endfunction

	// Advance the model by one request and return the result it yields
	function automatic gate_out_t predict_gate(req_t r);
		gate_out_t o;
		int lw, rw, lt, rt, spd, aim, room;
		bit dm, up, dn, es, enabled, neutral;
		o.st = ST_STOPPED;
		case (kind_t'(r.kind))
		KIND_COMMAND: begin
			lw = clip(int'($signed(r.left_stick)), int'(DRIVE_MIN), int'(DRIVE_MAX));
			rw = clip(int'($signed(r.right_stick)), int'(DRIVE_MIN), int'(DRIVE_MAX));
			lt = clip(int'($signed(r.left_trigger)), 0, int'(LEVEL_MAX));
			rt = clip(int'($signed(r.right_trigger)), 0, int'(LEVEL_MAX));
			dm = r.deadman;
			up = r.speed_up;
			dn = r.speed_down;
			es = r.estop_request;
			// Latch on estop, release only when the dead-man bit drops
			if (es) latch_estop = 1'b1;
			if (!dm) latch_estop = 1'b0;
			enabled = dm && !latch_estop;
			// Step the speed target on a single d-pad press once the interval is up
			if (!es && enabled && (up != dn)
					&& (!stepped || step_age >= cfg_now.speed_repeat_ticks)) begin
				if (up)
					spd_target = clip(spd_target + int'(cfg_now.speed_step), 0, int'(LEVEL_MAX));
				else
					spd_target = clip(spd_target - int'(cfg_now.speed_step), 0, int'(LEVEL_MAX));
				stepped = 1'b1;
				step_age = 0;
			end
			spd = spd_target;
			if (!enabled) begin
				spd_target = 0;
				stepped = 1'b0;
				step_age = 0;
				lw = 0;
				rw = 0;
				lt = 0;
				rt = 0;
				spd = 0;
			end
			cmd_age = 0;
			cmd_seen = 1'b1;
			neutral = !es && !enabled && !up && !dn;
			if (!is_armed && !neutral) begin
				clear_motion();
				o.st = ST_WAIT;
			end else begin
				is_armed = 1'b1;
				hold_l = lw;
				hold_r = rw;
				hold_spd = spd;
				// Slew the vector toward the trigger target, nearer one on a conflict
				aim = 0;
				if (lt > int'(cfg_now.servo_deadband) && rt > int'(cfg_now.servo_deadband))
					aim = (mag(-lt - vec_pos) <= mag(rt - vec_pos)) ? -lt : rt;
				else if (lt > int'(cfg_now.servo_deadband))
					aim = -lt;
				else if (rt > int'(cfg_now.servo_deadband))
					aim = rt;
				room = int'(cfg_now.servo_max_step);
				if (aim - vec_pos > room)
					vec_pos += room;
				else if (aim - vec_pos < -room)
					vec_pos -= room;
				else
					vec_pos = aim;
				o.st = ST_APPLIED;
			end
		end
		KIND_TICK: begin
			step_age = (step_age >= AGE_TOP) ? AGE_TOP : step_age + 1;
			cmd_age = (cmd_age >= AGE_TOP) ? AGE_TOP : cmd_age + 1;
			if (!cmd_seen || cmd_age > cfg_now.timeout_ticks)
				clear_motion();
			else
				o.st = ST_HELD;
		end
		default: begin
			if (r.kind == KIND_SESSION) is_armed = 1'b0;
			clear_motion();
		end
		endcase
		o.drive_l = 8'(hold_l);
		o.drive_r = 8'(hold_r);
		o.vector = 8'(vec_pos);
		o.speed = 7'(hold_spd);
		o.armed = is_armed;
		return o;
	endfunction

	function automatic req_t make_cmd(input logic signed [7:0] ls, rs, lt, rt,
			input logic dm, up, dn, es);
		req_t r;
		r.kind = KIND_COMMAND;
		r.left_stick = ls;
		r.right_stick = rs;
		r.left_trigger = lt;
		r.right_trigger = rt;
		r.deadman = dm;
		r.speed_up = up;
		r.speed_down = dn;
		r.estop_request = es;
		return r;
	endfunction

	// Request with every field random
	function automatic req_t random_req();
		return req_t'(REQ_W'({$urandom, $urandom}));
	endfunction

	// Non-command request with junk in the ignored fields
	function automatic req_t make_other(kind_t k);
		req_t r;
		r = random_req();
		r.kind = k;
		return r;
	endfunction

	function automatic int biased_value(int lo, int hi, int soft_hi);
		int pick;
		pick = $urandom_range(0, 5);
		if (pick == 0) return lo;
		if (pick == 1) return hi;
		return $urandom_range(lo, soft_hi);
	endfunction

	// Offer one request in bursts with random gaps, then record its result
	task automatic send_req(input req_t r);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 160)
				: $urandom_range(1, 20);
			if (sender_gaps) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		kind <= r.kind;
		left_stick <= r.left_stick;
		right_stick <= r.right_stick;
		left_trigger <= r.left_trigger;
		right_trigger <= r.right_trigger;
		deadman <= r.deadman;
		speed_up <= r.speed_up;
		speed_down <= r.speed_down;
		estop_request <= r.estop_request;
		do begin
			@(posedge clk);
			if (!req_ready) input_stalls++;
		end while (!req_ready);
		gate_outputs_due.push_back(predict_gate(r));
		sent_items++;
	endtask

	// Hold the request channel and wait for every outstanding result
	task automatic settle();
		req_valid <= 1'b0;
		burst_left = 0;
		while (gate_outputs_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		settle();
		put_reg(REG_DEADBAND, CFG_DATA_W'(c.servo_deadband));
		put_reg(REG_MAX_STEP, CFG_DATA_W'(c.servo_max_step));
		put_reg(REG_TIMEOUT, CFG_DATA_W'(c.timeout_ticks));
		put_reg(REG_SPD_STEP, CFG_DATA_W'(c.speed_step));
		put_reg(REG_REPEAT, CFG_DATA_W'(c.speed_repeat_ticks));
		cfg_we <= 1'b0;
		cfg_now = c;
		cfg_sets++;
	endtask

	task automatic test_power_up_and_arming();
		send_req(make_other(KIND_TICK));
		send_req(make_cmd(0, 0, 0, 0, 1, 0, 0, 1));
		send_req(make_cmd(0, 0, 0, 0, 0, 1, 0, 0));
		send_req(make_cmd(127, -128, 100, -128, 0, 0, 0, 0));
	endtask

	task automatic test_enabled_drive();
		send_req(make_cmd(127, -128, -128, 127, 1, 1, 0, 0));
		send_req(make_cmd(10, 20, 0, 0, 1, 1, 0, 0));
		send_req(make_cmd(-50, 50, 30, 30, 1, 1, 1, 0));
		send_req(make_other(KIND_TICK));
		send_req(make_other(KIND_FAULT));
		// Equal distance to both trigger targets picks the left one
		send_req(make_cmd(0, 0, 30, 30, 1, 0, 0, 0));
		// Left trigger sits at the deadband and does not count
		send_req(make_cmd(0, 0, 5, 6, 1, 0, 1, 0));
	endtask

	task automatic test_estop_and_session();
		send_req(make_cmd(60, 60, 40, 0, 1, 1, 0, 1));
		send_req(make_cmd(60, 60, 40, 0, 1, 0, 0, 0));
		send_req(make_cmd(60, 60, 40, 0, 0, 0, 0, 0));
		send_req(make_other(KIND_SESSION));
		send_req(make_cmd(0, 0, 0, 0, 1, 0, 1, 0));
	endtask

	task automatic test_register_limits();
		cfg_t c;
		c = '{servo_deadband: 7'd0, servo_max_step: 8'd200, timeout_ticks: 16'd1,
			speed_step: 7'd100, speed_repeat_ticks: 16'd0};
		apply_config(c);
		send_req(make_cmd(-1, 1, 0, 0, 0, 0, 0, 0));
		send_req(make_cmd(100, -100, 1, 0, 1, 1, 0, 0));
		send_req(make_cmd(100, -100, 0, 100, 1, 1, 0, 0));
		send_req(make_cmd(-101, 101, 100, 0, 1, 0, 1, 0));
		send_req(make_cmd(-101, 101, 0, 0, 1, 0, 1, 0));
		send_req(make_other(KIND_TICK));
		send_req(make_other(KIND_TICK));
		c = '{servo_deadband: 7'd99, servo_max_step: 8'd1, timeout_ticks: 16'd65535,
			speed_step: 7'd0, speed_repeat_ticks: 16'd65535};
		apply_config(c);
		send_req(make_cmd(0, 0, 100, 0, 1, 1, 0, 0));
		send_req(make_cmd(0, 0, 0, 127, 1, 0, 0, 0));
	endtask

	// Run a long stretch of ticks back to back under the largest timeout
	task automatic test_long_idle();
		cfg_t c;
		c = '{servo_deadband: 7'd100, servo_max_step: 8'd1, timeout_ticks: 16'd65535,
			speed_step: 7'd7, speed_repeat_ticks: 16'd65535};
		apply_config(c);
		sender_gaps = 1'b0;
		send_req(make_cmd(0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_cmd(0, 0, 100, 100, 1, 1, 0, 0));
		repeat (40) send_req(make_other(KIND_TICK));
		send_req(make_cmd(0, 0, 0, 0, 1, 1, 0, 0));
		settle();
		sender_gaps = 1'b1;
	endtask

	// Enabled command with random content; estop and d-pad presses mixed in
	function automatic req_t drive_cmd();
		int pad;
		pad = $urandom_range(0, 7);
		return make_cmd(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1,
			pad <= 1 || pad == 4, pad == 2 || pad == 3 || pad == 4,
			$urandom_range(0, 15) == 0);
	endfunction

	task automatic test_back_pressure();
		settle();
		sender_gaps = 1'b0;
		hold_wanted = 1'b1;
		send_req(make_cmd(0, 0, 0, 0, 0, 0, 0, 0));
		repeat (15) begin
			if ($urandom_range(0, 2) == 0)
				send_req(make_other(KIND_TICK));
			else
				send_req(drive_cmd());
		end
		settle();
		sender_gaps = 1'b1;
	endtask

	task automatic drive_step();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			send_req(drive_cmd());
		else if (pick < 80)
			repeat (($urandom_range(0, 4) == 0) ? $urandom_range(1, 48) : $urandom_range(1, 3))
				send_req(make_other(KIND_TICK));
		else if (pick < 88)
			send_req(make_cmd(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0,
				$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
				$urandom_range(0, 3) == 0));
		else if (pick < 92)
			send_req(make_other(KIND_FAULT));
		else if (pick < 95)
			send_req(make_other(KIND_SESSION));
		else
			send_req(random_req());
	endtask

	task automatic test_random_traffic();
		cfg_t c;
		int start;
		repeat (6) begin
			c.servo_deadband = 7'(biased_value(0, 100, 100));
			c.servo_max_step = 8'(biased_value(1, 200, 200));
			c.timeout_ticks = 16'(biased_value(1, 65535, 60));
			c.speed_step = 7'(biased_value(0, 100, 40));
			c.speed_repeat_ticks = 16'(biased_value(0, 65535, 30));
			apply_config(c);
			start = sent_items;
			while (sent_items - start < 150) begin
				if ($urandom_range(0, 9) == 0) begin
					send_req(random_req());
				end else begin
					// Neutral command first: arms the gate and releases the latch
					send_req(make_cmd(8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 0, 0, 0, 0));
					repeat ($urandom_range(4, 40)) drive_step();
				end
			end
		end
	endtask

	// Receiver: stall on shifting patterns, and hold off for a long stretch on demand
	initial begin
		int mode;
		int len;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(10, 120);
			repeat (len) begin
				@(posedge clk);
				if (hold_wanted) begin
					res_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
					hold_wanted = 1'b0;
				end else begin
					case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(0, 1));
					2: res_ready <= ($urandom_range(0, 3) == 0);
					default: res_ready <= ~res_ready;
					endcase
				end
			end
		end
	end

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin
		gate_out_t got;
		gate_out_t want;
		if (arst_n && res_valid && res_ready) begin
			got.drive_l = left_wing_out;
			got.drive_r = right_wing_out;
			got.vector = vector_out;
			got.speed = speed_out;
			got.armed = armed_out;
			got.st = status_t'(status);
			checked++;
			status_hits[status]++;
			if (gate_outputs_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result with none outstanding, status %0d", $time, status);
			end else begin
				want = gate_outputs_due.pop_front();
				if (got.drive_l !== want.drive_l || got.drive_r !== want.drive_r
						|| got.vector !== want.vector || got.speed !== want.speed
						|| got.armed !== want.armed || got.st !== want.st) begin
					failures++;
					if (failures <= 10) begin
						$display("%0t: mismatch on result %0d: expected L=%0d R=%0d V=%0d S=%0d A=%0d st=%0d",
							$time, checked, want.drive_l, want.drive_r, want.vector,
							want.speed, want.armed, want.st);
						$display("%0t: mismatch on result %0d: got L=%0d R=%0d V=%0d S=%0d A=%0d st=%0d",
							$time, checked, got.drive_l, got.drive_r, got.vector,
							got.speed, got.armed, got.st);
					end
				end
			end
		end
	end

	// Hard limit on the run
	initial begin
		#10_000_000;
		$display("run exceeded its time limit with %0d results outstanding",
			gate_outputs_due.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int guard;
		cfg_now = '{servo_deadband: DEADBAND_RST, servo_max_step: MAX_STEP_RST,
			timeout_ticks: TIMEOUT_RST, speed_step: SPD_STEP_RST,
			speed_repeat_ticks: REPEAT_RST};
		latch_estop = 1'b1;
		is_armed = 1'b0;
		stepped = 1'b0;
		cmd_seen = 1'b0;
		spd_target = 0;
		vec_pos = 0;
		hold_l = 0;
		hold_r = 0;
		hold_spd = 0;
		step_age = 0;
		cmd_age = 0;
		status_hits = '{default: 0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_and_arming();
		test_enabled_drive();
		test_estop_and_session();
		test_register_limits();
		test_back_pressure();
		test_long_idle();
		test_random_traffic();

		// Drain what is left, then let the pipeline settle before the final check
		req_valid <= 1'b0;
		for (guard = 0; guard < 50000 && gate_outputs_due.size() != 0; guard++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (gate_outputs_due.size() != 0) begin
			failures += gate_outputs_due.size();
			$display("%0d expected results never arrived", gate_outputs_due.size());
		end

		$display("Covered %0d requests under %0d register settings, %0d input stall cycles.",
			sent_items, cfg_sets, input_stalls);
		$display("Checked %0d results (applied %0d, waiting %0d, stopped %0d, held %0d), %0d bad.",
			checked, status_hits[ST_APPLIED], status_hits[ST_WAIT], status_hits[ST_STOPPED],
			status_hits[ST_HELD], failures);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
